// ===== rtl/core/hva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_pkg
// Shared types and constants of the Hough vote accumulator.
// ----------------------------------------------------------------------------
package hva_pkg;

  // transaction commands
  typedef enum logic [1:0] {
    CMD_VOTE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TRIG  = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic [2:0] CFG_R_MIN       = 3'd0;
  localparam logic [2:0] CFG_R_MAX       = 3'd1;
  localparam logic [2:0] CFG_R_BIN_RECIP = 3'd2;
  localparam logic [2:0] CFG_CONFORMAL   = 3'd3;
  localparam logic [2:0] CFG_THETA_BINS  = 3'd4;
  localparam logic [2:0] CFG_R_BINS      = 3'd5;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [30:0] MAG_SAT   = 31'h7FFF_FFFF;

  // quotient bits produced by the inversion divider (mag << 36 is 68 bits)
  localparam int DIV_STEPS = 68;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_DEN,
    ST_DIVU_GO,
    ST_DIVU,
    ST_DIVV_GO,
    ST_DIVV,
    ST_TRIG,
    ST_MC,
    ST_MS,
    ST_SUM,
    ST_RANGE,
    ST_BIN,
    ST_CELL,
    ST_RDCMD,
    ST_RDDAT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/hough_vote_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_vote_accumulator
// Hough line vote stage: optional conformal inversion of a hit, then at most one
// vote per active theta bin into a saturating count store.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_ready is low while it runs. A vote
// without inversion steps through each active theta bin in turn (trig read,
// two products on the shared multiplier, sum, range test, bin product, count
// read-modify-write), dropping the last two steps for a bin whose r falls
// outside the range. With inversion it first forms two squares on the
// multiplier and their sum, then runs two 68-step divisions on the serial
// divider, each after its own start state. A hit at the origin under
// inversion casts no vote. A clear sweeps the store one cell a cycle.
// After reset the store is swept clear before in_ready rises; configuration
// writes are taken throughout. A finished result sits in the output register
// while the next transaction is accepted.
// ----------------------------------------------------------------------------
module hough_vote_accumulator
  import hva_pkg::*;
#(
  parameter int NBIN_THETA = 64,
  parameter int NBIN_R     = 64
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] coord_a,
  input  logic signed [31:0] coord_b,
  input  logic [9:0]         theta_index,
  input  logic [9:0]         r_index,
  input  logic signed [15:0] sine_value,
  input  logic signed [15:0] cosine_value,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        bin_count,
  output logic [15:0]        vote_max,
  output logic               degenerate_hit
);

  localparam int CELLS  = NBIN_THETA * NBIN_R;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int TB_W   = $clog2(NBIN_THETA);
  localparam int RB_W   = $clog2(NBIN_R);
  localparam int NT_W   = $clog2(NBIN_THETA + 1);
  localparam int NR_W   = $clog2(NBIN_R + 1);
  localparam int R_W    = 40;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

  // configuration registers
  logic signed [31:0] r_min;
  logic signed [31:0] r_max;
  logic [31:0]        r_bin_recip;
  logic               conformal_map;
  logic [10:0]        theta_bins_used;
  logic [10:0]        r_bins_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_min           <= 32'sh8000_0000;
      r_max           <= 32'sh7FFF_FFFF;
      r_bin_recip     <= 32'd65536;
      conformal_map   <= 1'b1;
      theta_bins_used <= 11'd64;
      r_bins_used     <= 11'd64;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_R_MIN:       r_min           <= cfg_wr_data;
        CFG_R_MAX:       r_max           <= cfg_wr_data;
        CFG_R_BIN_RECIP: r_bin_recip     <= cfg_wr_data;
        CFG_CONFORMAL:   conformal_map   <= cfg_wr_data[0];
        CFG_THETA_BINS:  theta_bins_used <= cfg_wr_data[10:0];
        CFG_R_BINS:      r_bins_used     <= cfg_wr_data[10:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic               in_acc;
  logic               out_load;
  cmd_t               cmd_in;

  // captured transaction
  logic signed [31:0] a_q, b_q;
  logic [9:0]         ti_q, ri_q;
  logic [15:0]        count_q;
  logic               degen_q;

  // vote datapath
  logic signed [35:0] u, v;
  logic signed [63:0] sq_a, p1, prod, sum;
  logic [63:0]        den;
  logic signed [R_W-1:0] r, lo_ext, hi_ext, diff;
  logic signed [35:0] mul_x;
  logic signed [32:0] mul_y;
  logic signed [68:0] mul_out;
  logic [NT_W-1:0]    t, nt, nt_val;
  logic [NR_W-1:0]    nr, nr_val;
  logic               last_t, out_rng;
  logic [ADDR_W-1:0]  row_base, cell_addr, cell_calc, rd_cell, clr_addr;
  logic [27:0]        bin_raw;
  logic [RB_W-1:0]    bin_c;
  logic               clr_result;
  logic [15:0]        running_max;
  logic [15:0]        inc;
  logic               rd_in_rng;
  logic [31:0]        mag_a, mag_b;
  logic [35:0]        quot_ext;

  // serial divider
  logic               div_start, div_done;
  logic [30:0]        div_quot;

  // memories
  logic signed [15:0] sin_mem [NBIN_THETA];
  logic signed [15:0] cos_mem [NBIN_THETA];
  logic signed [15:0] sin_q, cos_q;
  logic               trig_we;
  logic               acc_we;
  logic [ADDR_W-1:0]  acc_waddr, acc_raddr;
  logic [15:0]        acc_wdata, acc_rdata;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);
  assign cmd_in   = cmd_t'(command);

  // bin counts clamped into [1, parameter]
  always_comb begin
    if (theta_bins_used == 11'd0)                 nt_val = NT_W'(1);
    else if (theta_bins_used > 11'(NBIN_THETA))   nt_val = NT_W'(NBIN_THETA);
    else                                          nt_val = NT_W'(theta_bins_used);
    if (r_bins_used == 11'd0)                     nr_val = NR_W'(1);
    else if (r_bins_used > 11'(NBIN_R))           nr_val = NR_W'(NBIN_R);
    else                                          nr_val = NR_W'(r_bins_used);
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_SQA:   begin mul_x = 36'(a_q);  mul_y = 33'(a_q);  end
      ST_SQB:   begin mul_x = 36'(b_q);  mul_y = 33'(b_q);  end
      ST_MC:    begin mul_x = u;         mul_y = 33'(cos_q); end
      ST_MS:    begin mul_x = v;         mul_y = 33'(sin_q); end
      ST_RANGE: begin
        mul_x = $signed({3'd0, diff[32:0]});
        mul_y = $signed({1'b0, r_bin_recip});
      end
      default:  begin mul_x = '0;        mul_y = '0;        end
    endcase
  end
  assign mul_out = mul_x * mul_y;

  // r path
  assign sum     = p1 + prod;
  assign lo_ext  = R_W'(r_min);
  assign hi_ext  = R_W'(r_max);
  assign diff    = r - lo_ext;
  assign out_rng = (r < lo_ext) || (r > hi_ext);
  assign last_t  = NT_W'(t + NT_W'(1)) == nt;

  // r bin, clamped into the last used bin
  assign bin_raw   = prod[63:36];
  assign bin_c     = (bin_raw >= 28'(nr)) ? RB_W'(nr - NR_W'(1)) : RB_W'(bin_raw);
  assign cell_calc = ADDR_W'(row_base + ADDR_W'(bin_c));
  assign inc       = (acc_rdata == COUNT_MAX) ? acc_rdata : 16'(acc_rdata + 16'd1);

  // read command addressing
  assign rd_in_rng = ({1'b0, ti_q} < 11'(NBIN_THETA)) && ({1'b0, ri_q} < 11'(NBIN_R));
  assign rd_cell   = ADDR_W'(32'(ti_q) * NBIN_R + 32'(ri_q));

  assign mag_a    = a_q[31] ? 32'(32'd0 - a_q) : a_q;
  assign mag_b    = b_q[31] ? 32'(32'd0 - b_q) : b_q;
  assign quot_ext = {5'd0, div_quot};

  // next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_CLEAR: if (clr_addr == LAST_CELL) state_next = clr_result ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_in)
            CMD_VOTE: begin
              if (!conformal_map)                  state_next = ST_TRIG;
              else if (coord_a == 0 && coord_b == 0) state_next = ST_DONE;
              else                                 state_next = ST_SQA;
            end
            CMD_READ:  state_next = ST_RDCMD;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_SQA:     state_next = ST_SQB;
      ST_SQB:     state_next = ST_DEN;
      ST_DEN:     state_next = ST_DIVU_GO;
      ST_DIVU_GO: begin div_start = 1'b1; state_next = ST_DIVU; end
      ST_DIVU:    if (div_done) state_next = ST_DIVV_GO;
      ST_DIVV_GO: begin div_start = 1'b1; state_next = ST_DIVV; end
      ST_DIVV:    if (div_done) state_next = ST_TRIG;
      ST_TRIG:    state_next = ST_MC;
      ST_MC:      state_next = ST_MS;
      ST_MS:      state_next = ST_SUM;
      ST_SUM:     state_next = ST_RANGE;
      ST_RANGE: begin
        if (!out_rng)    state_next = ST_BIN;
        else if (last_t) state_next = ST_DONE;
        else             state_next = ST_TRIG;
      end
      ST_BIN:     state_next = ST_CELL;
      ST_CELL:    state_next = last_t ? ST_DONE : ST_TRIG;
      ST_RDCMD:   state_next = ST_RDDAT;
      ST_RDDAT:   state_next = ST_DONE;
      ST_DONE:    if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      clr_result  <= 1'b0;
      t           <= '0;
      row_base    <= '0;
      running_max <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr    <= ADDR_W'(clr_addr + 1'b1);
        running_max <= '0;
      end
      if (in_acc) begin
        t          <= '0;
        row_base   <= '0;
        clr_addr   <= '0;
        clr_result <= 1'b1;
      end
      // step to the next theta bin
      if ((state == ST_RANGE && out_rng) || state == ST_CELL) begin
        t        <= NT_W'(t + NT_W'(1));
        row_base <= ADDR_W'(row_base + ADDR_W'(NBIN_R));
      end
      if (state == ST_CELL && inc > running_max) running_max <= inc;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_out[63:0];
    if (in_acc) begin
      a_q     <= coord_a;
      b_q     <= coord_b;
      ti_q    <= theta_index;
      ri_q    <= r_index;
      nt      <= nt_val;
      nr      <= nr_val;
      count_q <= '0;
      degen_q <= (cmd_in == CMD_VOTE) && conformal_map && coord_a == 0 && coord_b == 0;
      u       <= {coord_a, 4'd0};
      v       <= {coord_b, 4'd0};
    end
    case (state)
      ST_SQB:   sq_a <= prod;
      ST_DEN:   den  <= 64'(sq_a + prod);
      ST_DIVU:  if (div_done) u <= a_q[31] ? -$signed(quot_ext) : $signed(quot_ext);
      ST_DIVV:  if (div_done) v <= b_q[31] ? -$signed(quot_ext) : $signed(quot_ext);
      ST_MS:    p1 <= prod;
      ST_SUM:   r <= $signed(sum[R_W+14:15]);
      ST_BIN:   cell_addr <= cell_calc;
      ST_RDDAT: count_q <= rd_in_rng ? acc_rdata : 16'd0;
      default: ;
    endcase
    if (out_load) begin
      bin_count      <= count_q;
      vote_max       <= running_max;
      degenerate_hit <= degen_q;
    end
  end

  // trig tables
  assign trig_we = in_acc && (cmd_in == CMD_TRIG) && ({1'b0, theta_index} < 11'(NBIN_THETA));

  always_ff @(posedge clk) begin
    if (trig_we) begin
      sin_mem[theta_index[TB_W-1:0]] <= sine_value;
      cos_mem[theta_index[TB_W-1:0]] <= cosine_value;
    end
    sin_q <= sin_mem[t[TB_W-1:0]];
    cos_q <= cos_mem[t[TB_W-1:0]];
  end

  // count store ports
  assign acc_we    = (state == ST_CLEAR) || (state == ST_CELL);
  assign acc_waddr = (state == ST_CLEAR) ? clr_addr : cell_addr;
  assign acc_wdata = (state == ST_CLEAR) ? 16'd0 : inc;
  assign acc_raddr = (state == ST_BIN) ? cell_calc : rd_cell;

  hva_acc_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  hva_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   ((state == ST_DIVU_GO) ? mag_a : mag_b),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

// ===== rtl/core/hva_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_divider
// Restoring divider, one quotient bit per cycle: (mag << 36) / den,
// saturated to 31 bits of magnitude.
// ----------------------------------------------------------------------------
module hva_divider
  import hva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] mag,
  input  logic [63:0] den,
  output logic        done,
  output logic [30:0] quot
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [67:0]       dvd;
  logic [63:0]       rem;
  logic [31:0]       q;
  logic              sat;
  logic [64:0]       rem_sh;
  logic              ge;

  // trial subtract
  assign rem_sh = {rem, dvd[67]};
  assign ge     = rem_sh >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= STEP_W'(step + 1'b1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {mag, 36'd0};
      rem <= '0;
      q   <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      rem <= ge ? 64'(rem_sh - {1'b0, den}) : rem_sh[63:0];
      dvd <= {dvd[66:0], 1'b0};
      q   <= {q[30:0], ge};
      sat <= sat | q[31];
    end
  end

  // any bit reaching bit 31 means the quotient saturates
  assign quot = (sat | q[31]) ? MAG_SAT : q[30:0];

endmodule

// ===== rtl/core/hva_acc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_acc_ram
// Vote count store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hva_acc_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/hva_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hva_checker
// Port-level checks on the Hough vote accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module hva_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] bin_count,
  input logic [15:0] vote_max,
  input logic        degenerate_hit
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // one transaction at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while one was running");

  // reset starts the clearing sweep with nothing to deliver
  a_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready or result right after reset");

  // no cell can exceed the running maximum
  a_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_count <= vote_max)
    else $error("bin count above vote maximum");

  // a skipped hit reports no count
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate_hit |-> bin_count == 16'd0)
    else $error("degenerate hit with a nonzero count");

endmodule

bind hough_vote_accumulator hva_checker u_hva_checker (.*);
